@@ hw/rtl/scatr_pkg.sv @@
// scatr_pkg: shared types and constants for the smartcard answer-to-reset parser
// no dependencies; imported by smartcard_atr_parser_core
package scatr_pkg;

  localparam int RX_W            = 8;
  localparam int NIB_W           = 4;
  localparam int IFACE_IDX_W     = 5;
  localparam int HIST_IDX_W      = 4;
  localparam int PROTO_W         = 4;
  localparam int MAX_IFACE_BYTES = 32;

  localparam logic [RX_W-1:0]  PAD_BYTE = 8'hFF;
  localparam logic [NIB_W-1:0] GRP_TD   = 4'b1000;

  typedef enum logic [2:0] {
    PH_TS,
    PH_T0,
    PH_IFACE,
    PH_HIST,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    CLS_PAD     = 3'd0,
    CLS_TS      = 3'd1,
    CLS_T0      = 3'd2,
    CLS_IFACE   = 3'd3,
    CLS_HIST    = 3'd4,
    CLS_IGNORED = 3'd5
  } byte_class_t;

endpackage

@@ hw/rtl/smartcard_atr_parser_core.sv @@
// smartcard_atr_parser_core: result registered, valid in the cycle after the transfer
// throughput one byte per cycle unless a held result stalls; the parse state and
// the result register both update on the accepting edge, so back-to-back transfers
// need no bubble; in_ready falls only while a result is held and out_ready is low
// rst_n is synchronous, active low: parse state returns to waiting for TS,
// first group flag set, counters and protocol cleared, no result pending
module smartcard_atr_parser_core #(
  parameter int MAX_INTERFACE_BYTES = scatr_pkg::MAX_IFACE_BYTES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // byte channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [scatr_pkg::RX_W-1:0]          in_rx_byte,
  input  logic                                in_atr_start,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_byte_class,
  output logic [scatr_pkg::IFACE_IDX_W-1:0]   out_interface_index,
  output logic [scatr_pkg::HIST_IDX_W-1:0]    out_historical_index,
  output logic [scatr_pkg::PROTO_W-1:0]       out_protocol,
  output logic                                out_atr_done,
  output logic                                out_overflow
);
  import scatr_pkg::*;

  // counter must be able to hold the bound itself for saturation
  localparam int CNT_W = $clog2(MAX_INTERFACE_BYTES + 1);

  // parse state
  phase_t             phase_r,     phase_nxt;
  logic [NIB_W-1:0]   grp_r,       grp_nxt;
  logic [CNT_W-1:0]   iface_cnt_r, iface_cnt_nxt;
  logic [NIB_W-1:0]   hist_tot_r,  hist_tot_nxt;
  logic [NIB_W-1:0]   hist_cnt_r,  hist_cnt_nxt;
  logic [PROTO_W-1:0] proto_r,     proto_nxt;
  logic               first_r,     first_nxt;

  // result register
  logic                   out_valid_r;
  byte_class_t            cls_r,  cls_nxt;
  logic [IFACE_IDX_W-1:0] iidx_r, iidx_nxt;
  logic [HIST_IDX_W-1:0]  hidx_r, hidx_nxt;
  logic [PROTO_W-1:0]     oproto_r;
  logic                   done_r, done_nxt;
  logic                   ovf_r,  ovf_nxt;

  // state as seen by this byte, after an optional restart
  phase_t             phase_cur;
  logic [NIB_W-1:0]   grp_cur;
  logic [CNT_W-1:0]   iface_cnt_cur;
  logic [NIB_W-1:0]   hist_tot_cur;
  logic [NIB_W-1:0]   hist_cnt_cur;
  logic [PROTO_W-1:0] proto_cur;
  logic               first_cur;

  logic [NIB_W-1:0] grp_low;     // lowest announced byte of the group
  logic [NIB_W-1:0] grp_after;
  logic [NIB_W-1:0] hist_inc;
  logic             in_xfer;

  // output register frees up whenever the held result is taken
  assign in_ready = ~out_valid_r | out_ready;
  assign in_xfer  = in_valid & in_ready;

  always_comb begin
    phase_cur     = in_atr_start ? PH_TS : phase_r;
    grp_cur       = in_atr_start ? '0 : grp_r;
    iface_cnt_cur = in_atr_start ? '0 : iface_cnt_r;
    hist_tot_cur  = in_atr_start ? '0 : hist_tot_r;
    hist_cnt_cur  = in_atr_start ? '0 : hist_cnt_r;
    proto_cur     = in_atr_start ? '0 : proto_r;
    first_cur     = in_atr_start ? 1'b1 : first_r;

    phase_nxt     = phase_cur;
    grp_nxt       = grp_cur;
    iface_cnt_nxt = iface_cnt_cur;
    hist_tot_nxt  = hist_tot_cur;
    hist_cnt_nxt  = hist_cnt_cur;
    proto_nxt     = proto_cur;
    first_nxt     = first_cur;

    cls_nxt  = CLS_IGNORED;
    iidx_nxt = '0;
    hidx_nxt = '0;
    done_nxt = 1'b0;
    ovf_nxt  = 1'b0;

    grp_low   = grp_cur & (~grp_cur + NIB_W'(1));
    grp_after = grp_cur & ~grp_low;
    hist_inc  = hist_cnt_cur + NIB_W'(1);

    unique case (phase_cur)
      PH_TS: begin
        // padding is skipped until the first real byte, which is TS
        if (in_rx_byte == PAD_BYTE) begin
          cls_nxt = CLS_PAD;
        end else begin
          cls_nxt   = CLS_TS;
          phase_nxt = PH_T0;
        end
      end
      PH_T0: begin
        cls_nxt      = CLS_T0;
        hist_tot_nxt = in_rx_byte[NIB_W-1:0];
        grp_nxt      = in_rx_byte[RX_W-1:NIB_W];
        first_nxt    = 1'b1;
        if (in_rx_byte[RX_W-1:NIB_W] != '0) begin
          phase_nxt = PH_IFACE;
        end else if (in_rx_byte[NIB_W-1:0] == '0) begin
          // neither interface nor historical bytes: T0 ends the answer
          phase_nxt = PH_DONE;
          done_nxt  = 1'b1;
        end else begin
          phase_nxt = PH_HIST;
        end
      end
      PH_IFACE: begin
        cls_nxt = CLS_IFACE;
        // index saturates once the bound is reached
        if (iface_cnt_cur >= CNT_W'(MAX_INTERFACE_BYTES)) begin
          iidx_nxt = IFACE_IDX_W'(MAX_INTERFACE_BYTES - 1);
          ovf_nxt  = 1'b1;
        end else begin
          iidx_nxt      = IFACE_IDX_W'(iface_cnt_cur);
          iface_cnt_nxt = iface_cnt_cur + CNT_W'(1);
        end
        // a TD byte replaces the group with the one it announces
        if (grp_low == GRP_TD) begin
          grp_after = in_rx_byte[RX_W-1:NIB_W];
          if (first_cur) begin
            proto_nxt = in_rx_byte[NIB_W-1:0];
            first_nxt = 1'b0;
          end
        end
        grp_nxt = grp_after;
        if (grp_after == '0) begin
          if (hist_tot_cur == '0) begin
            phase_nxt = PH_DONE;
            done_nxt  = 1'b1;
          end else begin
            phase_nxt = PH_HIST;
          end
        end
      end
      PH_HIST: begin
        cls_nxt      = CLS_HIST;
        hidx_nxt     = hist_cnt_cur;
        hist_cnt_nxt = hist_inc;
        if (hist_inc == hist_tot_cur) begin
          phase_nxt = PH_DONE;
          done_nxt  = 1'b1;
        end
      end
      PH_DONE: begin
        cls_nxt = CLS_IGNORED;
      end
      default: begin
        cls_nxt = CLS_IGNORED;
      end
    endcase
  end

  // parse state register, advanced on every input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TS;
      grp_r       <= '0;
      iface_cnt_r <= '0;
      hist_tot_r  <= '0;
      hist_cnt_r  <= '0;
      proto_r     <= '0;
      first_r     <= 1'b1;
    end else if (in_xfer) begin
      phase_r     <= phase_nxt;
      grp_r       <= grp_nxt;
      iface_cnt_r <= iface_cnt_nxt;
      hist_tot_r  <= hist_tot_nxt;
      hist_cnt_r  <= hist_cnt_nxt;
      proto_r     <= proto_nxt;
      first_r     <= first_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // result payload, loaded only on a transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cls_r    <= cls_nxt;
      iidx_r   <= iidx_nxt;
      hidx_r   <= hidx_nxt;
      oproto_r <= proto_nxt;
      done_r   <= done_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_byte_class       = cls_r;
  assign out_interface_index  = iidx_r;
  assign out_historical_index = hidx_r;
  assign out_protocol         = oproto_r;
  assign out_atr_done         = done_r;
  assign out_overflow         = ovf_r;

`ifndef ASSERT_OFF
  // overflow is only ever reported on an interface byte
  a_ovf_iface: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ovf_r |-> cls_r == CLS_IFACE)
    else $error("overflow flagged on a non-interface byte");

  // the answer can only complete on T0, an interface or a historical byte
  a_done_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |->
      cls_r == CLS_T0 || cls_r == CLS_IFACE || cls_r == CLS_HIST)
    else $error("answer completed on an unexpected byte class");

  // once finished, bytes are ignored until a restart
  a_done_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_atr_start && phase_r == PH_DONE |=> cls_r == CLS_IGNORED)
    else $error("byte after the end not classed as ignored");

  // interface counter never passes its bound
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iface_cnt_r <= CNT_W'(MAX_INTERFACE_BYTES))
    else $error("interface byte counter beyond bound");
`endif

endmodule

@@ bench/smartcard_atr_parser_core_test.sv @@
// smartcard_atr_parser_core_test: self-checking bench for the answer-to-reset parser
// needs scatr_pkg and smartcard_atr_parser_core; a queue-fed driver, a clocked monitor
// and an in-bench model of the parse state predict every result
module smartcard_atr_parser_core_test;
  import scatr_pkg::*;

  localparam int IFACE_BOUND = MAX_IFACE_BYTES;
  localparam int BYTE_TARGET = 1750;
  // the sender waits for a full drain before this byte goes out
  localparam int DRAIN_AT    = 900;
  // results seen before the receiver's long hold-off
  localparam int HOLD_AT     = 400;
  localparam int HOLD_LEN    = 80;
  // bytes left in the queue when all idling stops
  localparam int CALM_TAIL   = 150;

  typedef struct {
    logic [RX_W-1:0] rx;
    logic            start;
    logic            drain;
  } card_byte_t;

  typedef struct {
    byte_class_t            cls;
    logic [IFACE_IDX_W-1:0] iidx;
    logic [HIST_IDX_W-1:0]  hidx;
    logic [PROTO_W-1:0]     proto;
    logic                   done;
    logic                   ovf;
  } atr_result_t;

  logic                   clk                  = 1'b0;
  logic                   rst_n                = 1'b0;
  logic                   in_valid             = 1'b0;
  logic                   in_ready;
  logic [RX_W-1:0]        in_rx_byte           = '0;
  logic                   in_atr_start         = 1'b0;
  logic                   out_valid;
  logic                   out_ready            = 1'b0;
  logic [2:0]             out_byte_class;
  logic [IFACE_IDX_W-1:0] out_interface_index;
  logic [HIST_IDX_W-1:0]  out_historical_index;
  logic [PROTO_W-1:0]     out_protocol;
  logic                   out_atr_done;
  logic                   out_overflow;

  smartcard_atr_parser_core i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .in_atr_start         (in_atr_start),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_byte_class       (out_byte_class),
    .out_interface_index  (out_interface_index),
    .out_historical_index (out_historical_index),
    .out_protocol         (out_protocol),
    .out_atr_done         (out_atr_done),
    .out_overflow         (out_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bytes still to be offered, and results still owed by the block
  card_byte_t  pending_q[$];
  atr_result_t expected_q[$];

  int bytes_queued   = 0;
  int answers_queued = 0;
  int bytes_sent     = 0;
  int results_seen   = 0;
  int answers_done   = 0;
  int overflow_hits  = 0;
  int mismatches     = 0;
  bit calm_tail      = 1'b0;

  // parse state of the bench model, at its reset values
  phase_t            ph        = PH_TS;
  logic [NIB_W-1:0]  grp       = '0;
  int unsigned       iface_cnt = 0;
  logic [NIB_W-1:0]  hist_total = '0;
  logic [NIB_W-1:0]  hist_cnt  = '0;
  logic [PROTO_W-1:0] proto    = '0;
  logic              first_grp = 1'b1;

  task automatic report_fault(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // leaving the interface bytes: on to the historical bytes, or finished
  function automatic logic leave_interface();
    if (hist_total == '0) begin
      ph = PH_DONE;
      return 1'b1;
    end
    ph = PH_HIST;
    return 1'b0;
  endfunction

  // advance the model by one received byte and return what the block should report
  function automatic atr_result_t parse_atr_byte(input logic [RX_W-1:0] b, input logic start);
    atr_result_t      r;
    logic [NIB_W-1:0] low_bit;
    r.cls  = CLS_IGNORED;
    r.iidx = '0;
    r.hidx = '0;
    r.done = 1'b0;
    r.ovf  = 1'b0;
    // restart clears everything, then the same byte opens the new answer
    if (start) begin
      ph         = PH_TS;
      grp        = '0;
      iface_cnt  = 0;
      hist_total = '0;
      hist_cnt   = '0;
      proto      = '0;
      first_grp  = 1'b1;
    end
    case (ph)
      PH_TS: begin
        if (b == PAD_BYTE) begin
          r.cls = CLS_PAD;
        end else begin
          r.cls = CLS_TS;
          ph    = PH_T0;
        end
      end
      PH_T0: begin
        r.cls      = CLS_T0;
        hist_total = b[3:0];
        grp        = b[7:4];
        first_grp  = 1'b1;
        // no interface bytes: straight to historical bytes or done on T0
        if (grp != '0) ph = PH_IFACE;
        else r.done = leave_interface();
      end
      PH_IFACE: begin
        // lowest announced byte of the group is the one arriving now
        low_bit = grp & (~grp + 4'd1);
        r.cls   = CLS_IFACE;
        if (iface_cnt >= IFACE_BOUND) begin
          r.iidx = IFACE_IDX_W'(IFACE_BOUND - 1);
          r.ovf  = 1'b1;
        end else begin
          r.iidx = IFACE_IDX_W'(iface_cnt);
          iface_cnt++;
        end
        if (low_bit == GRP_TD) begin
          // TD replaces the group with its own nibble; TD1 names the protocol
          grp = b[7:4];
          if (first_grp) begin
            proto     = b[3:0];
            first_grp = 1'b0;
          end
        end else begin
          grp = grp & ~low_bit;
        end
        if (grp == '0) r.done = leave_interface();
      end
      PH_HIST: begin
        r.cls    = CLS_HIST;
        r.hidx   = hist_cnt;
        hist_cnt = hist_cnt + 4'd1;
        if (hist_cnt == hist_total) begin
          r.done = 1'b1;
          ph     = PH_DONE;
        end
      end
      default: r.cls = CLS_IGNORED;
    endcase
    r.proto = proto;
    return r;
  endfunction

  task automatic push_byte(input logic [RX_W-1:0] b, input logic start);
    card_byte_t item;
    item.rx    = b;
    item.start = start;
    item.drain = (bytes_queued == DRAIN_AT);
    pending_q.push_back(item);
    bytes_queued++;
  endtask

  // one answer with random content: padding, TS, T0, chained groups, historical
  // bytes; fill forces full groups for long chains, cut truncates it early
  task automatic add_answer(input int pads, input int depth, input bit fill, input int cut,
                            input int trail);
    logic [RX_W-1:0]  ans[$];
    logic [RX_W-1:0]  b;
    logic [NIB_W-1:0] pres;
    int               groups;
    int               n;
    groups = 0;
    repeat (pads) ans.push_back(PAD_BYTE);
    if ($urandom_range(0, 1) == 0) begin
      b = $urandom_range(0, 1) ? 8'h3B : 8'h3F;
    end else begin
      b = RX_W'($urandom_range(0, 254));
    end
    ans.push_back(b);
    b = RX_W'($urandom);
    if (fill) b[7:4] = 4'hF;
    ans.push_back(b);
    pres = b[7:4];
    n    = b[3:0];
    while (pres != '0) begin
      if (pres[0]) ans.push_back(RX_W'($urandom));
      if (pres[1]) ans.push_back(RX_W'($urandom));
      if (pres[2]) ans.push_back(RX_W'($urandom));
      if (pres[3]) begin
        groups++;
        b = RX_W'($urandom);
        if (groups >= depth) b[7] = 1'b0;
        else if (fill) b[7:4] = 4'hF;
        ans.push_back(b);
        pres = b[7:4];
      end else begin
        pres = '0;
      end
    end
    repeat (n) ans.push_back(RX_W'($urandom));
    if (cut > 0 && cut < ans.size()) n = cut;
    else n = ans.size();
    for (int i = 0; i < n; i++) push_byte(ans[i], i == 0);
    // anything after the end should come back as ignored
    repeat (trail) push_byte(RX_W'($urandom), 1'b0);
    answers_queued++;
  endtask

  // driver: offers queued bytes, idles in bursts, predicts on each transfer
  int send_gap  = 0;
  int send_free = 0;

  always @(posedge clk) begin : byte_driver
    card_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(parse_atr_byte(in_rx_byte, in_atr_start));
        bytes_sent++;
      end
      calm_tail = (pending_q.size() < CALM_TAIL);
      if (send_free > 0) send_free--;
      else if ($urandom_range(0, 99) == 0) send_free = 50;
      // a byte still waiting for ready stays put
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!calm_tail && send_free == 0 && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 && !(pending_q[0].drain && expected_q.size() != 0)) begin
          nxt = pending_q.pop_front();
          in_valid     <= 1'b1;
          in_rx_byte   <= nxt.rx;
          in_atr_start <= nxt.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest prediction
  int  recv_gap  = 0;
  int  recv_free = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin : result_monitor
    atr_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_fault("result transfer with no byte outstanding");
        end else begin
          want = expected_q.pop_front();
          if (out_byte_class !== want.cls)
            report_fault($sformatf("byte class got %0d expected %0d", out_byte_class, want.cls));
          if (out_interface_index !== want.iidx)
            report_fault($sformatf("interface index got %0d expected %0d",
                                   out_interface_index, want.iidx));
          if (out_historical_index !== want.hidx)
            report_fault($sformatf("historical index got %0d expected %0d",
                                   out_historical_index, want.hidx));
          if (out_protocol !== want.proto)
            report_fault($sformatf("protocol got %0d expected %0d", out_protocol, want.proto));
          if (out_atr_done !== want.done)
            report_fault($sformatf("atr done got %0b expected %0b", out_atr_done, want.done));
          if (out_overflow !== want.ovf)
            report_fault($sformatf("overflow got %0b expected %0b", out_overflow, want.ovf));
          results_seen++;
          if (want.done) answers_done++;
          if (want.ovf) overflow_hits++;
        end
      end
      // one long hold-off so the block fills and stalls its input
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (recv_free > 0) recv_free--;
      else if ($urandom_range(0, 99) == 0) recv_free = 50;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!calm_tail && recv_free == 0 && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int kind;
    int spins;
    // directed: padding then T0 with nothing announced, then a byte after the end
    push_byte(PAD_BYTE, 1'b1);
    push_byte(PAD_BYTE, 1'b0);
    push_byte(8'h3B, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hAA, 1'b0);
    // full first group, TD1 ends the chain with protocol 1, two historical bytes
    push_byte(8'h3F, 1'b1);
    push_byte(8'hF2, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h00, 1'b0);
    // TD chain: TD2 announces only TA, later protocol nibble must not stick
    push_byte(8'h3B, 1'b1);
    push_byte(8'h81, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h1F, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h77, 1'b0);
    // restart in the middle of an answer, landing on padding
    push_byte(8'h3B, 1'b1);
    push_byte(8'hF0, 1'b0);
    push_byte(PAD_BYTE, 1'b1);
    push_byte(8'h3B, 1'b0);
    push_byte(8'h0F, 1'b0);

    // random: mostly well-formed answers, some long chains, cut answers and noise
    while (bytes_queued < BYTE_TARGET) begin
      kind = $urandom_range(0, 19);
      if (kind <= 13) begin
        add_answer(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                   $urandom_range(1, 4), 1'b0, 0, $urandom_range(0, 2));
      end else if (kind == 14) begin
        add_answer(0, $urandom_range(8, 10), 1'b1, 0, $urandom_range(0, 1));
      end else if (kind <= 16) begin
        add_answer($urandom_range(0, 1), $urandom_range(1, 4), 1'b0, $urandom_range(1, 8), 0);
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(RX_W'($urandom), $urandom_range(0, 3) == 0);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (bytes_sent == bytes_queued);
    spins = 0;
    while (expected_q.size() != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    if (expected_q.size() != 0)
      report_fault($sformatf("%0d results never arrived", expected_q.size()));
    // then keep watching to catch any stray result
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d answers and noise runs, checked %0d results",
             bytes_sent, answers_queued, results_seen);
    $display("%0d answers completed, %0d interface overflow results", answers_done,
             overflow_hits);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
